[rtl/core/tpd_pkg.sv]
// ----------------------------------------------------------------------------
// tpd_pkg
// shared types and constants of the touch press detector
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CH_W       = 2;
    localparam int PCT_SCALE  = 100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IIR_SHIFT = 2'd3;

    // opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SEED   = 1'b1;

    // register reset values
    localparam logic [3:0] DEBOUNCE_RST  = 4'd3;
    localparam logic [7:0] STUCK_RST     = 8'd20;
    localparam logic [6:0] THRESHOLD_RST = 7'd80;
    localparam logic [3:0] IIR_SHIFT_RST = 4'd6;

    localparam logic [7:0] STUCK_SAT = 8'hFF;

    typedef struct packed {
        logic [3:0] debounce_samples;
        logic [7:0] stuck_limit;
        logic [6:0] threshold_percent;
        logic [3:0] iir_shift;
    } t_cfg;

    // per-channel control state, stored beside the baseline
    typedef struct packed {
        logic [3:0] low_run;
        logic [7:0] stuck_run;
        logic       prev_pressed;
        logic       armed_flag;
    } t_ctrl_state;

    localparam t_ctrl_state CTRL_RST = '{
        low_run:      4'd0,
        stuck_run:    8'd0,
        prev_pressed: 1'b0,
        armed_flag:   1'b1
    };

    typedef struct packed {
        logic press_event;
        logic below_threshold;
        logic pressed_level;
        logic stuck_release;
    } t_flags;

endpackage

[rtl/core/touch_press_detector.sv]
// ----------------------------------------------------------------------------
// touch_press_detector
// per-channel capacitive press detection with baseline tracking and debounce
// ----------------------------------------------------------------------------
// Takes one sample or seed command per cycle while the output is not stalled
// and returns one result per item, through the read stage and then the output
// register. The per-channel state lives in a ram read at transfer in and
// written back as the item leaves the read stage; a same-channel write-back
// at transfer in is forwarded, so items for one channel may follow each other
// back to back. Valid bits give unwritten channels their reset state, so no
// clearing pass is needed after reset. The configuration port takes a write
// in any cycle and is meant to be written only while no item is in flight.
module touch_press_detector #(
    parameter int CHANNELS    = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [tpd_pkg::CH_W-1:0]          i_channel,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [tpd_pkg::CH_W-1:0]          o_channel_out,
    output logic                              o_press_event,
    output logic                              o_below_threshold,
    output logic                              o_pressed_level,
    output logic                              o_stuck_release,
    output logic [SAMPLE_BITS-1:0]            o_baseline_out
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $bits(tpd_pkg::t_ctrl_state);
    localparam int MW = SAMPLE_BITS + CW;

    tpd_pkg::t_cfg r_cfg;

    logic                     r_s1_valid;
    logic                     r_s1_op;
    logic [tpd_pkg::CH_W-1:0] r_s1_ch;
    logic [SAMPLE_BITS-1:0]   r_s1_sample;
    logic                     r_s1_vld_hit;
    logic                     r_fwd_hit;
    logic [MW-1:0]            r_fwd_data;

    logic [CHANNELS-1:0]      r_vld;

    logic                     r_out_valid;
    logic [tpd_pkg::CH_W-1:0] r_out_ch;
    tpd_pkg::t_flags          r_out_flags;
    logic [SAMPLE_BITS-1:0]   r_out_baseline;

    logic                     accept;
    logic                     s1_adv;
    logic                     in_range;
    logic                     s1_in_range;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic                     wr_en;
    logic [MW-1:0]            wr_data;
    logic [MW-1:0]            rd_data;
    logic [MW-1:0]            cur;
    logic [SAMPLE_BITS-1:0]   upd_baseline;
    tpd_pkg::t_ctrl_state     upd_state;
    tpd_pkg::t_flags          upd_flags;

    assign in_range    = (int'(i_channel) < CHANNELS);
    assign s1_in_range = (int'(r_s1_ch) < CHANNELS);
    assign rd_addr     = AW'(i_channel);
    assign wr_addr     = AW'(r_s1_ch);

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign wr_en      = r_s1_valid && s1_adv && s1_in_range;
    assign wr_data    = {upd_baseline, upd_state};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_samples  <= tpd_pkg::DEBOUNCE_RST;
            r_cfg.stuck_limit       <= tpd_pkg::STUCK_RST;
            r_cfg.threshold_percent <= tpd_pkg::THRESHOLD_RST;
            r_cfg.iir_shift         <= tpd_pkg::IIR_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tpd_pkg::CFG_DEBOUNCE: begin
                    r_cfg.debounce_samples <= i_cfg_data[3:0];
                end
                tpd_pkg::CFG_STUCK: begin
                    r_cfg.stuck_limit <= i_cfg_data[7:0];
                end
                tpd_pkg::CFG_THRESHOLD: begin
                    r_cfg.threshold_percent <= i_cfg_data[6:0];
                end
                tpd_pkg::CFG_IIR_SHIFT: begin
                    r_cfg.iir_shift <= i_cfg_data[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    tpd_ram #(
        .WIDTH (MW),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (accept && in_range),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // written-once flags, reset state until a channel is first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // read stage payload and forward of the write in the same cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op      <= i_opcode;
            r_s1_ch      <= i_channel;
            r_s1_sample  <= i_sample;
            r_s1_vld_hit <= in_range && r_vld[rd_addr];
            r_fwd_hit    <= wr_en && (r_s1_ch == i_channel);
            r_fwd_data   <= wr_data;
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            cur = r_fwd_data;
        end else if (r_s1_vld_hit) begin
            cur = rd_data;
        end else begin
            cur = {{SAMPLE_BITS{1'b0}}, tpd_pkg::CTRL_RST};
        end
    end

    tpd_update #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_update (
        .i_cfg      (r_cfg),
        .i_opcode   (r_s1_op),
        .i_in_range (s1_in_range),
        .i_sample   (r_s1_sample),
        .i_baseline (cur[MW-1:CW]),
        .i_state    (tpd_pkg::t_ctrl_state'(cur[CW-1:0])),
        .o_baseline (upd_baseline),
        .o_state    (upd_state),
        .o_flags    (upd_flags)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_ch       <= r_s1_ch;
            r_out_flags    <= upd_flags;
            r_out_baseline <= upd_baseline;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_channel_out     = r_out_ch;
    assign o_press_event     = r_out_flags.press_event;
    assign o_below_threshold = r_out_flags.below_threshold;
    assign o_pressed_level   = r_out_flags.pressed_level;
    assign o_stuck_release   = r_out_flags.stuck_release;
    assign o_baseline_out    = r_out_baseline;

endmodule

[rtl/core/tpd_ram.sv]
// ----------------------------------------------------------------------------
// tpd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module tpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/tpd_update.sv]
// ----------------------------------------------------------------------------
// tpd_update
// per-channel sample or seed step: threshold compare, baseline tracking, debounce, stuck
// recovery and press edge detect
// ----------------------------------------------------------------------------
module tpd_update #(
    parameter int SAMPLE_BITS = 16
) (
    input  tpd_pkg::t_cfg        i_cfg,
    input  logic                 i_opcode,
    input  logic                 i_in_range,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_baseline,
    input  tpd_pkg::t_ctrl_state i_state,
    output logic [SAMPLE_BITS-1:0] o_baseline,
    output tpd_pkg::t_ctrl_state o_state,
    output tpd_pkg::t_flags      o_flags
);

    localparam int PW = SAMPLE_BITS + 7;

    logic [PW-1:0]          prod;
    logic [PW-1:0]          rhs;
    logic                   below;
    logic [SAMPLE_BITS-1:0] tracked;
    logic [3:0]             dc;
    logic [7:0]             sc;
    logic                   pressed;
    logic                   stuck;
    logic                   armed;

    // below when 100 * (sample + 1) <= baseline * percent
    assign prod = PW'(i_baseline) * PW'(i_cfg.threshold_percent);
    assign rhs  = PW'(i_sample) * PW'(tpd_pkg::PCT_SCALE) + PW'(tpd_pkg::PCT_SCALE);
    assign below = (rhs <= prod);

    assign tracked = i_baseline - (i_baseline >> i_cfg.iir_shift)
                   + (i_sample >> i_cfg.iir_shift);

    always_comb begin
        dc      = i_state.low_run;
        sc      = i_state.stuck_run;
        stuck   = 1'b0;
        armed   = i_state.armed_flag;
        if (below) begin
            if (dc < i_cfg.debounce_samples) begin
                dc = dc + 4'd1;
            end
        end else begin
            dc = 4'd0;
        end
        pressed = (dc >= i_cfg.debounce_samples);
        if (below) begin
            if (sc < tpd_pkg::STUCK_SAT) begin
                sc = sc + 8'd1;
            end
            if (sc > i_cfg.stuck_limit) begin
                stuck = 1'b1;
                sc    = 8'd0;
                dc    = 4'd0;
                armed = 1'b0;
            end
        end else begin
            sc    = 8'd0;
            armed = 1'b1;
        end
    end

    always_comb begin
        o_baseline = i_baseline;
        o_state    = i_state;
        o_flags    = '0;
        if (!i_in_range) begin
            o_baseline = '0;
        end else if (i_opcode == tpd_pkg::OP_SEED) begin
            o_baseline            = i_sample;
            o_flags.pressed_level = i_state.prev_pressed;
        end else begin
            if (!below && (i_baseline != '0)) begin
                o_baseline = tracked;
            end
            o_state.low_run         = dc;
            o_state.stuck_run       = sc;
            o_state.armed_flag      = armed;
            o_state.prev_pressed    = pressed;
            o_flags.press_event     = pressed && !i_state.prev_pressed && armed;
            o_flags.below_threshold = below;
            o_flags.pressed_level   = pressed;
            o_flags.stuck_release   = stuck;
        end
    end

endmodule
